// ----- design/ssr_pkg.sv -----
// ----------------------------------------------------------------------------
// ssr_pkg
// Types, constants and the segment decode table shared by the seven-segment
// rectangle generator.
// ----------------------------------------------------------------------------
package ssr_pkg;

  localparam int unsigned SegCount  = 7;
  localparam int unsigned CoordW    = 16;
  localparam int unsigned ColorW    = 16;
  localparam int unsigned DigitW    = 4;
  localparam int unsigned ThickW    = 8;
  localparam int unsigned SegIdW    = 3;
  localparam logic [DigitW-1:0] DigitMax = 4'd9;

  // Input tdata layout, from the lowest bit up.
  localparam int unsigned InDataW  = 64;
  // Output tdata layout, from the lowest bit up.
  localparam int unsigned OutDataW = 80;

  typedef enum logic [SegIdW-1:0] {
    SEG_A = 3'd0,
    SEG_B = 3'd1,
    SEG_C = 3'd2,
    SEG_D = 3'd3,
    SEG_E = 3'd4,
    SEG_F = 3'd5,
    SEG_G = 3'd6
  } seg_id_e;

  typedef logic [CoordW-1:0] coord_t;

  // One decoded digit waiting to be drawn: the lit segments and the cell
  // grid lines. Column lines x0..x3 and row lines y0..y5 are the edges of the
  // bands of the cell; the last of each lies one past the cell's far edge.
  typedef struct packed {
    logic [SegCount-1:0] mask;
    coord_t              x0;
    coord_t              x1;
    coord_t              x2;
    coord_t              x3;
    coord_t              y0;
    coord_t              y1;
    coord_t              y2;
    coord_t              y3;
    coord_t              y4;
    coord_t              y5;
    logic [ColorW-1:0]   color;
  } seg_job_t;

  // Standard seven-segment patterns, bit 0 is segment a.
  function automatic logic [SegCount-1:0] seg_decode(input logic [DigitW-1:0] digit);
    logic [SegCount-1:0] pat;
    case (digit)
      4'd0:    pat = 7'h3F;
      4'd1:    pat = 7'h06;
      4'd2:    pat = 7'h5B;
      4'd3:    pat = 7'h4F;
      4'd4:    pat = 7'h66;
      4'd5:    pat = 7'h6D;
      4'd6:    pat = 7'h7D;
      4'd7:    pat = 7'h07;
      4'd8:    pat = 7'h7F;
      4'd9:    pat = 7'h6F;
      default: pat = '0;
    endcase
    return pat;
  endfunction

endpackage

// ----- design/ssr_front.sv -----
// ----------------------------------------------------------------------------
// ssr_front
// Accepts digit items, drops digits above nine and turns the others into a
// segment mask plus the grid lines of the digit cell.
// ----------------------------------------------------------------------------
module ssr_front (
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [ssr_pkg::InDataW-1:0]   s_axis_tdata_i,
  input  logic                          q_full_i,
  output logic                          q_push_o,
  output ssr_pkg::seg_job_t             q_job_o
);

  logic [ssr_pkg::DigitW-1:0] digit;
  ssr_pkg::coord_t            org_x;
  ssr_pkg::coord_t            org_y;
  logic [ssr_pkg::ThickW-1:0] thick;
  ssr_pkg::coord_t            t16;
  ssr_pkg::coord_t            len16;
  logic                       drawable;

  assign digit = s_axis_tdata_i[3:0];
  assign org_x = s_axis_tdata_i[19:4];
  assign org_y = s_axis_tdata_i[35:20];
  assign thick = s_axis_tdata_i[43:36];

  assign t16   = {8'd0, thick};
  assign len16 = {6'd0, thick, 2'd0};

  assign drawable        = (digit <= ssr_pkg::DigitMax);
  // Digits that draw nothing are taken and dropped even when the queue is full.
  assign s_axis_tready_o = !q_full_i || !drawable;
  assign q_push_o        = s_axis_tvalid_i && !q_full_i && drawable;

  always_comb begin
    q_job_o.mask  = ssr_pkg::seg_decode(digit);
    q_job_o.x0    = org_x;
    q_job_o.x1    = org_x + t16;
    q_job_o.x2    = org_x + t16 + len16;
    q_job_o.x3    = org_x + t16 + t16 + len16;
    q_job_o.y0    = org_y;
    q_job_o.y1    = org_y + t16;
    q_job_o.y2    = org_y + t16 + len16;
    q_job_o.y3    = org_y + t16 + t16 + len16;
    q_job_o.y4    = org_y + t16 + t16 + len16 + len16;
    q_job_o.y5    = org_y + t16 + t16 + t16 + len16 + len16;
    q_job_o.color = s_axis_tdata_i[59:44];
  end

endmodule

// ----- design/ssr_queue.sv -----
// ----------------------------------------------------------------------------
// ssr_queue
// Short first-in first-out queue of decoded digits between front and back.
// ----------------------------------------------------------------------------
module ssr_queue #(
  parameter int unsigned Depth = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  ssr_pkg::seg_job_t job_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output ssr_pkg::seg_job_t job_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  ssr_pkg::seg_job_t mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;
  logic              do_push;
  logic              do_pop;

  assign full_o  = (count_q == FullCnt);
  assign valid_o = (count_q != '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;
  assign job_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

// ----- design/ssr_back.sv -----
// ----------------------------------------------------------------------------
// ssr_back
// Walks the lit segments of one digit, lowest first, and sends one rectangle
// per cycle while the receiver is ready, through a registered output stage.
// ----------------------------------------------------------------------------
module ssr_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          q_valid_i,
  input  ssr_pkg::seg_job_t             q_job_i,
  output logic                          q_pop_o,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [ssr_pkg::OutDataW-1:0]  m_axis_tdata_o,   // left, top, right, bottom, color
  output logic [ssr_pkg::SegIdW-1:0]    m_axis_tuser_o,   // segment_id
  output logic                          m_axis_tlast_o
);

  logic [ssr_pkg::SegCount-1:0] mask_q, mask_d, mask_clr;
  ssr_pkg::seg_job_t            job_q;
  logic                         out_valid_q, out_valid_d;
  logic [ssr_pkg::OutDataW-1:0] out_data_q;
  ssr_pkg::seg_id_e             out_id_q;
  logic                         out_last_q;

  ssr_pkg::seg_id_e             sel_id;
  logic                         found;
  logic                         emit;
  ssr_pkg::coord_t              r_left, r_top, r_right, r_bottom;

  // Lowest lit segment still to be drawn.
  always_comb begin
    sel_id = ssr_pkg::SEG_A;
    found  = 1'b0;
    for (int i = 0; i < ssr_pkg::SegCount; i++) begin
      if (mask_q[i] && !found) begin
        sel_id = ssr_pkg::seg_id_e'(3'(i));
        found  = 1'b1;
      end
    end
  end

  assign mask_clr = mask_q & ~(7'd1 << sel_id);
  assign emit     = (mask_q != '0) && (!out_valid_q || m_axis_tready_i);
  // The next digit is loaded in the same cycle that the current one finishes.
  assign q_pop_o  = q_valid_i && ((mask_q == '0) || (emit && (mask_clr == '0)));

  always_comb begin
    unique case (sel_id)
      ssr_pkg::SEG_A: begin
        r_left = job_q.x1; r_top = job_q.y0;
        r_right = job_q.x2 - 1'b1; r_bottom = job_q.y1 - 1'b1;
      end
      ssr_pkg::SEG_B: begin
        r_left = job_q.x2; r_top = job_q.y1;
        r_right = job_q.x3 - 1'b1; r_bottom = job_q.y2 - 1'b1;
      end
      ssr_pkg::SEG_C: begin
        r_left = job_q.x2; r_top = job_q.y3;
        r_right = job_q.x3 - 1'b1; r_bottom = job_q.y4 - 1'b1;
      end
      ssr_pkg::SEG_D: begin
        r_left = job_q.x1; r_top = job_q.y4;
        r_right = job_q.x2 - 1'b1; r_bottom = job_q.y5 - 1'b1;
      end
      ssr_pkg::SEG_E: begin
        r_left = job_q.x0; r_top = job_q.y3;
        r_right = job_q.x1 - 1'b1; r_bottom = job_q.y4 - 1'b1;
      end
      ssr_pkg::SEG_F: begin
        r_left = job_q.x0; r_top = job_q.y1;
        r_right = job_q.x1 - 1'b1; r_bottom = job_q.y2 - 1'b1;
      end
      ssr_pkg::SEG_G: begin
        r_left = job_q.x1; r_top = job_q.y2;
        r_right = job_q.x2 - 1'b1; r_bottom = job_q.y3 - 1'b1;
      end
      default: begin
        r_left = job_q.x0; r_top = job_q.y0;
        r_right = job_q.x0; r_bottom = job_q.y0;
      end
    endcase
  end

  always_comb begin
    mask_d = mask_q;
    if (q_pop_o) begin
      mask_d = q_job_i.mask;
    end else if (emit) begin
      mask_d = mask_clr;
    end
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      mask_q      <= mask_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      job_q <= q_job_i;
    end
    if (emit) begin
      out_data_q <= {job_q.color, r_bottom, r_right, r_top, r_left};
      out_id_q   <= sel_id;
      out_last_q <= (mask_clr == '0);
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_id_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule

// ----- design/seven_segment_rect_generator.sv -----
// ----------------------------------------------------------------------------
// seven_segment_rect_generator
// Turns a decimal digit into the inclusive rectangles of its lit segments.
// ----------------------------------------------------------------------------
// A digit with n lit segments gives n rectangles (two to seven), one per
// cycle while the receiver is ready, from the back end that walks the segment
// mask; a digit above nine is taken and gives nothing. The input side
// keeps accepting into a short queue while rectangles are still leaving, so
// back-to-back digits stream without gaps. Rectangles come in segment order
// a to g, tlast marks the final one of a digit, and all coordinates wrap
// modulo 65536.
module seven_segment_rect_generator #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // digit[3:0], origin_x[19:4], origin_y[35:20], thickness[43:36],
  // fill_color[59:44], zero fill above
  input  logic [ssr_pkg::InDataW-1:0]   s_axis_tdata_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // rect_left[15:0], rect_top[31:16], rect_right[47:32], rect_bottom[63:48],
  // rect_color[79:64]
  output logic [ssr_pkg::OutDataW-1:0]  m_axis_tdata_o,
  // segment_id[2:0]
  output logic [ssr_pkg::SegIdW-1:0]    m_axis_tuser_o,
  output logic                          m_axis_tlast_o
);

  logic              q_full;
  logic              q_push;
  logic              q_pop;
  logic              q_valid;
  ssr_pkg::seg_job_t push_job;
  ssr_pkg::seg_job_t head_job;

  ssr_front u_front (
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .q_full_i        (q_full),
    .q_push_o        (q_push),
    .q_job_o         (push_job)
  );

  ssr_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .job_i   (push_job),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .job_o   (head_job)
  );

  ssr_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_valid_i       (q_valid),
    .q_job_i         (head_job),
    .q_pop_o         (q_pop),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

endmodule

// ----- dv/tb_seven_segment_rect_generator.sv -----
// ----------------------------------------------------------------------------
// tb_seven_segment_rect_generator
// Self-checking bench for the seven-segment rectangle generator.
// ----------------------------------------------------------------------------
// Digits are streamed in on the slave side. Each accepted transfer is turned
// into the rectangles its lit segments should produce, and every rectangle
// on the master side is checked field by field against the oldest one still
// due. A directed set covers every digit, the blank codes above nine and the
// coordinate extremes. A random set follows, with idle bursts on both sides,
// one long receiver hold-off and a quiet tail.
`timescale 1ns / 1ps

module tb_seven_segment_rect_generator;

  localparam int unsigned RandomItems = 150;
  localparam int unsigned TailItems   = 30;
  localparam int unsigned HoldItem    = 60;
  localparam int unsigned HoldBurst   = 12;
  localparam int unsigned LongHold    = 400;
  localparam int unsigned DrainCycles = 40;

  typedef struct packed {
    logic [ssr_pkg::DigitW-1:0] digit;
    ssr_pkg::coord_t            x;
    ssr_pkg::coord_t            y;
    logic [ssr_pkg::ThickW-1:0] thick;
    logic [ssr_pkg::ColorW-1:0] color;
  } digit_item_t;

  typedef struct packed {
    ssr_pkg::coord_t            left;
    ssr_pkg::coord_t            top;
    ssr_pkg::coord_t            right;
    ssr_pkg::coord_t            bottom;
    logic [ssr_pkg::ColorW-1:0] color;
    ssr_pkg::seg_id_e           seg;
    logic                       last;
  } rect_t;

  class rect_checker;
    rect_t       rects_due[$];
    int unsigned mismatches;
    int unsigned rects_checked;
    int unsigned blank_digits;

    function new();
      mismatches    = 0;
      rects_checked = 0;
      blank_digits  = 0;
    endfunction

    function logic [ssr_pkg::SegCount-1:0] lit_segments(logic [ssr_pkg::DigitW-1:0] digit);
      logic [ssr_pkg::SegCount-1:0] lit;
      case (digit)
        4'd0:    lit = 7'b0111111;
        4'd1:    lit = 7'b0000110;
        4'd2:    lit = 7'b1011011;
        4'd3:    lit = 7'b1001111;
        4'd4:    lit = 7'b1100110;
        4'd5:    lit = 7'b1101101;
        4'd6:    lit = 7'b1111101;
        4'd7:    lit = 7'b0000111;
        4'd8:    lit = 7'b1111111;
        4'd9:    lit = 7'b1101111;
        default: lit = '0;
      endcase
      return lit;
    endfunction

    // The cell is cut by four column lines and six row lines; each segment
    // spans from one line up to one pixel short of another.
    function void note_digit(digit_item_t it);
      ssr_pkg::coord_t              t;
      ssr_pkg::coord_t              len;
      ssr_pkg::coord_t              col[4];
      ssr_pkg::coord_t              row[6];
      ssr_pkg::coord_t              l, tp, r_line, b_line;
      logic [ssr_pkg::SegCount-1:0] lit;
      int                           top_seg;
      rect_t                        r;
      t      = ssr_pkg::coord_t'(it.thick);
      len    = t << 2;
      col[0] = it.x;
      col[1] = it.x + t;
      col[2] = col[1] + len;
      col[3] = col[2] + t;
      row[0] = it.y;
      row[1] = it.y + t;
      row[2] = row[1] + len;
      row[3] = row[2] + t;
      row[4] = row[3] + len;
      row[5] = row[4] + t;
      lit     = lit_segments(it.digit);
      top_seg = -1;
      for (int s = 0; s < ssr_pkg::SegCount; s++) begin
        if (lit[s]) top_seg = s;
      end
      if (top_seg < 0) blank_digits++;
      for (int s = 0; s < ssr_pkg::SegCount; s++) begin
        if (lit[s]) begin
          case (ssr_pkg::seg_id_e'(s))
            ssr_pkg::SEG_A: begin
              l = col[1]; tp = row[0]; r_line = col[2]; b_line = row[1];
            end
            ssr_pkg::SEG_B: begin
              l = col[2]; tp = row[1]; r_line = col[3]; b_line = row[2];
            end
            ssr_pkg::SEG_C: begin
              l = col[2]; tp = row[3]; r_line = col[3]; b_line = row[4];
            end
            ssr_pkg::SEG_D: begin
              l = col[1]; tp = row[4]; r_line = col[2]; b_line = row[5];
            end
            ssr_pkg::SEG_E: begin
              l = col[0]; tp = row[3]; r_line = col[1]; b_line = row[4];
            end
            ssr_pkg::SEG_F: begin
              l = col[0]; tp = row[1]; r_line = col[1]; b_line = row[2];
            end
            default: begin
              l = col[1]; tp = row[2]; r_line = col[2]; b_line = row[3];
            end
          endcase
          r.left   = l;
          r.top    = tp;
          r.right  = r_line - 16'd1;
          r.bottom = b_line - 16'd1;
          r.color  = it.color;
          r.seg    = ssr_pkg::seg_id_e'(s);
          r.last   = (s == top_seg);
          rects_due.push_back(r);
        end
      end
    endfunction

    function void field_check(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void check_rect(rect_t got);
      rect_t want;
      if (rects_due.size() == 0) begin
        $display("%0t: unexpected rectangle, expected none, actual seg %0d left %h top %h",
                 $time, got.seg, got.left, got.top);
        mismatches++;
        return;
      end
      want = rects_due.pop_front();
      rects_checked++;
      field_check("rect_left",   want.left,   got.left);
      field_check("rect_top",    want.top,    got.top);
      field_check("rect_right",  want.right,  got.right);
      field_check("rect_bottom", want.bottom, got.bottom);
      field_check("rect_color",  want.color,  got.color);
      field_check("segment_id",  16'(want.seg),  16'(got.seg));
      field_check("last_rect",   16'(want.last), 16'(got.last));
    endfunction
  endclass

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         s_axis_tvalid = 1'b0;
  logic [ssr_pkg::InDataW-1:0]  s_axis_tdata = '0;
  logic                         s_axis_tready;
  logic                         m_axis_tvalid;
  logic                         m_axis_tready = 1'b0;
  logic [ssr_pkg::OutDataW-1:0] m_axis_tdata;
  logic [ssr_pkg::SegIdW-1:0]   m_axis_tuser;
  logic                         m_axis_tlast;

  rect_checker rect_chk;
  rect_t       rect_seen;
  bit          sink_hold_req = 1'b0;
  bit          tail_phase = 1'b0;
  int unsigned digits_sent = 0;

  always #5 clk_i = ~clk_i;

  seven_segment_rect_generator dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tuser_o  (m_axis_tuser),
    .m_axis_tlast_o  (m_axis_tlast)
  );

  function automatic digit_item_t make_digit(logic [3:0] d, ssr_pkg::coord_t x,
                                             ssr_pkg::coord_t y, logic [7:0] t,
                                             logic [15:0] c);
    digit_item_t it;
    it.digit = d;
    it.x     = x;
    it.y     = y;
    it.thick = t;
    it.color = c;
    return it;
  endfunction

  function automatic digit_item_t make_random_digit();
    digit_item_t it;
    int unsigned pick;
    if ($urandom_range(0, 99) < 88) it.digit = 4'($urandom_range(0, 9));
    else it.digit = 4'($urandom_range(10, 15));
    it.x     = 16'($urandom);
    it.y     = 16'($urandom);
    it.color = 16'($urandom);
    // Push some cells right against the top of the coordinate space.
    if ($urandom_range(0, 4) == 0) it.x = 16'hFFFF - 16'($urandom_range(0, 63));
    if ($urandom_range(0, 4) == 0) it.y = 16'hFFFF - 16'($urandom_range(0, 255));
    pick = $urandom_range(0, 9);
    if (pick == 0) it.thick = 8'd0;
    else if (pick == 1) it.thick = 8'hFF;
    else if (pick < 5) it.thick = 8'($urandom_range(1, 8));
    else it.thick = 8'($urandom);
    return it;
  endfunction

  // Called at a rising edge; returns at the edge where the transfer happened.
  task automatic send_digit(input digit_item_t it);
    s_axis_tdata  <= {4'b0, it.color, it.thick, it.y, it.x, it.digit};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    rect_chk.note_digit(it);
    digits_sent++;
  endtask

  task automatic idle_source(input int unsigned cycles);
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= {$urandom, $urandom};
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic maybe_idle_source();
    if (!tail_phase && $urandom_range(0, 9) < 3) idle_source($urandom_range(1, 19));
  endtask

  task automatic wait_all_rects();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (rect_chk.rects_due.size() != 0);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      rect_seen.left   = m_axis_tdata[15:0];
      rect_seen.top    = m_axis_tdata[31:16];
      rect_seen.right  = m_axis_tdata[47:32];
      rect_seen.bottom = m_axis_tdata[63:48];
      rect_seen.color  = m_axis_tdata[79:64];
      rect_seen.seg    = ssr_pkg::seg_id_e'(m_axis_tuser);
      rect_seen.last   = m_axis_tlast;
      rect_chk.check_rect(rect_seen);
    end
  end

  // Receiver: random stalls, ready stretches, and one long hold-off on request.
  initial begin : sink
    int unsigned n;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      if (sink_hold_req) begin
        m_axis_tready <= 1'b0;
        sink_hold_req = 1'b0;
        repeat (LongHold) @(posedge clk_i);
      end else if (!tail_phase && $urandom_range(0, 9) < 3) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        n = $urandom_range(1, 40);
        while (n > 0 && !sink_hold_req) begin
          @(posedge clk_i);
          n--;
        end
      end
    end
  end

  initial begin : stimulus
    int unsigned burst;
    rect_chk = new();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Every digit once, at ordinary positions.
    for (int d = 0; d <= 9; d++) begin
      send_digit(make_digit(4'(d), 16'(100 + 40 * d), 16'd200, 8'(d + 1),
                            16'(16'h1111 * d)));
      maybe_idle_source();
    end
    // Codes above nine draw nothing.
    for (int d = 10; d <= 15; d++) begin
      send_digit(make_digit(4'(d), 16'hFFFF, 16'h0000, 8'hFF, 16'hFFFF));
    end
    // Zero thickness wraps the right and bottom edges below the origin.
    send_digit(make_digit(4'd8, 16'h0000, 16'h0000, 8'd0, 16'h0000));
    send_digit(make_digit(4'd8, 16'h0000, 16'h0000, 8'd1, 16'hFFFF));
    // Wide segments near the top of the coordinate space wrap coordinates past it.
    send_digit(make_digit(4'd8, 16'hFFFF, 16'hFFFF, 8'hFF, 16'hA5A5));
    send_digit(make_digit(4'd0, 16'hFF00, 16'hFC00, 8'hFF, 16'h5A5A));
    send_digit(make_digit(4'd2, 16'hFFFE, 16'h8000, 8'h80, 16'hF800));

    // Sender waits for the block to drain completely before the random part.
    wait_all_rects();

    burst = 0;
    for (int unsigned n = 0; n < RandomItems; n++) begin
      tail_phase = (n >= RandomItems - TailItems);
      if (n == HoldItem) begin
        sink_hold_req = 1'b1;
        burst = HoldBurst;
      end
      send_digit(make_random_digit());
      if (burst > 0) burst--;
      else maybe_idle_source();
    end

    wait_all_rects();
    repeat (DrainCycles) @(posedge clk_i);

    $display("Drove %0d digits (%0d blank codes) and checked %0d rectangles,",
             digits_sent, rect_chk.blank_digits, rect_chk.rects_checked);
    $display("including zero and full thickness, wrapped edges and a long output stall.");
    if (rect_chk.mismatches == 0 && rect_chk.rects_due.size() == 0) begin
      $display("PASS seven_segment_rect_generator");
    end else begin
      $display("%0d mismatches, %0d rectangles never arrived",
               rect_chk.mismatches, rect_chk.rects_due.size());
      $display("FAIL seven_segment_rect_generator");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("Timed out with %0d rectangles still due", rect_chk.rects_due.size());
    $display("FAIL seven_segment_rect_generator");
    $finish;
  end

endmodule
